// ===== rtl/lpca_pkg.sv =====
package lpca_pkg;

	localparam int CW        = 16;          // coordinate width, Q8.8
	localparam int DW        = CW + 1;      // point difference / sum width
	localparam int PW        = 2 * DW + 2;  // dot product width
	localparam int QW        = 2 * PW;      // denominator and numerator of r2
	localparam int FSH       = 16;          // fraction bits of the line parameters
	localparam int RW        = 32;          // line parameter width, Q16.16
	localparam int N2_W      = QW + FSH;    // scaled numerator of r2
	localparam int D1_W      = 104;         // den * v2, and r1 numerator before scaling
	localparam int N1_W      = D1_W + FSH;  // scaled numerator of r1
	localparam int GAP_W     = 17;          // distance width, Q9.8
	localparam int ROOT_IN_W = 2 * GAP_W;   // square root radicand width
	localparam int IN_W      = 12 * CW;
	localparam int OUT_W     = 136;

	typedef logic [2:0][CW-1:0] cvec_t;
	typedef logic [2:0][DW-1:0] dvec_t;

	// geometry carried alongside the dividers
	typedef struct packed {
		dvec_t ac;
		dvec_t g;
		dvec_t v;
		dvec_t w;
	} geom_t;

	typedef struct packed {
		logic          valid_res;
		logic [RW-1:0] param_line1;
		logic [RW-1:0] param_line2;
		cvec_t         mid;
	} res_t;

endpackage

// ===== rtl/lpca_front.sv =====
module lpca_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  lpca_pkg::cvec_t                   a,
	input  lpca_pkg::cvec_t                   b,
	input  lpca_pkg::cvec_t                   c,
	input  lpca_pkg::cvec_t                   d,
	output logic                              out_valid,
	output logic signed [lpca_pkg::N2_W-1:0]  num2,
	output logic signed [lpca_pkg::QW-1:0]    den2,
	output logic signed [lpca_pkg::N1_W-1:0]  num1,
	output logic signed [lpca_pkg::D1_W-1:0]  den1,
	output lpca_pkg::geom_t                   geom
);
	import lpca_pkg::*;

	localparam int NST   = 8;
	localparam int SPL   = PW;        // low slice of the wide operand, unsigned
	localparam int PRD_W = QW + PW;

	logic [NST-1:0] vld_s;

	geom_t geom_s [1:NST];

	logic [2:0][2*DW-1:0] pvv_s2, pww_s2, pvw_s2, pgv_s2, pgw_s2;

	logic signed [PW-1:0] v2_s3, w2_s3, vw_s3, gv_s3, gw_s3;

	logic signed [QW-1:0] m_a_s4, m_b_s4, m_c_s4, m_d_s4;
	logic signed [PW-1:0] v2_s4, vw_s4, gv_s4;

	logic signed [QW-1:0] den_s5, num_s5;
	logic signed [PW-1:0] v2_s5, vw_s5, gv_s5;

	logic signed [QW:0]   nl_s6, gl_s6, dl_s6;
	logic signed [QW-1:0] nh_s6, gh_s6, dh_s6;
	logic signed [QW-1:0] den_s6, num_s6;

	logic signed [PRD_W-1:0] nv_s7, gd_s7, dv_s7;
	logic signed [QW-1:0]    den_s7, num_s7;

	logic signed [N1_W-1:0] num1_s8;
	logic signed [D1_W-1:0] den1_s8;
	logic signed [N2_W-1:0] num2_s8;
	logic signed [QW-1:0]   den2_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NST-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// differences and sums of the end points
			for (int i = 0; i < 3; i++) begin
				geom_s[1].v[i]  <= DW'($signed(b[i])) - DW'($signed(a[i]));
				geom_s[1].w[i]  <= DW'($signed(d[i])) - DW'($signed(c[i]));
				geom_s[1].g[i]  <= DW'($signed(a[i])) - DW'($signed(c[i]));
				geom_s[1].ac[i] <= DW'($signed(a[i])) + DW'($signed(c[i]));
			end
			for (int j = 2; j <= NST; j++) begin
				geom_s[j] <= geom_s[j-1];
			end

			for (int i = 0; i < 3; i++) begin
				pvv_s2[i] <= $signed(geom_s[1].v[i]) * $signed(geom_s[1].v[i]);
				pww_s2[i] <= $signed(geom_s[1].w[i]) * $signed(geom_s[1].w[i]);
				pvw_s2[i] <= $signed(geom_s[1].v[i]) * $signed(geom_s[1].w[i]);
				pgv_s2[i] <= $signed(geom_s[1].g[i]) * $signed(geom_s[1].v[i]);
				pgw_s2[i] <= $signed(geom_s[1].g[i]) * $signed(geom_s[1].w[i]);
			end

			v2_s3 <= PW'($signed(pvv_s2[0])) + PW'($signed(pvv_s2[1])) + PW'($signed(pvv_s2[2]));
			w2_s3 <= PW'($signed(pww_s2[0])) + PW'($signed(pww_s2[1])) + PW'($signed(pww_s2[2]));
			vw_s3 <= PW'($signed(pvw_s2[0])) + PW'($signed(pvw_s2[1])) + PW'($signed(pvw_s2[2]));
			gv_s3 <= PW'($signed(pgv_s2[0])) + PW'($signed(pgv_s2[1])) + PW'($signed(pgv_s2[2]));
			gw_s3 <= PW'($signed(pgw_s2[0])) + PW'($signed(pgw_s2[1])) + PW'($signed(pgw_s2[2]));

			m_a_s4 <= v2_s3 * w2_s3;
			m_b_s4 <= vw_s3 * vw_s3;
			m_c_s4 <= v2_s3 * gw_s3;
			m_d_s4 <= gv_s3 * vw_s3;
			v2_s4  <= v2_s3;
			vw_s4  <= vw_s3;
			gv_s4  <= gv_s3;

			den_s5 <= m_a_s4 - m_b_s4;
			num_s5 <= m_c_s4 - m_d_s4;
			v2_s5  <= v2_s4;
			vw_s5  <= vw_s4;
			gv_s5  <= gv_s4;

			// split the wide operand into an unsigned low and a signed high part
			nl_s6  <= $signed({1'b0, num_s5[SPL-1:0]}) * vw_s5;
			nh_s6  <= $signed(num_s5[QW-1:SPL]) * vw_s5;
			gl_s6  <= $signed({1'b0, den_s5[SPL-1:0]}) * gv_s5;
			gh_s6  <= $signed(den_s5[QW-1:SPL]) * gv_s5;
			dl_s6  <= $signed({1'b0, den_s5[SPL-1:0]}) * v2_s5;
			dh_s6  <= $signed(den_s5[QW-1:SPL]) * v2_s5;
			den_s6 <= den_s5;
			num_s6 <= num_s5;

			nv_s7  <= (PRD_W'(nh_s6) <<< SPL) + PRD_W'(nl_s6);
			gd_s7  <= (PRD_W'(gh_s6) <<< SPL) + PRD_W'(gl_s6);
			dv_s7  <= (PRD_W'(dh_s6) <<< SPL) + PRD_W'(dl_s6);
			den_s7 <= den_s6;
			num_s7 <= num_s6;

			num1_s8 <= {nv_s7[D1_W-1:0] - gd_s7[D1_W-1:0], {FSH{1'b0}}};
			den1_s8 <= dv_s7[D1_W-1:0];
			num2_s8 <= {num_s7, {FSH{1'b0}}};
			den2_s8 <= den_s7;
		end
	end

	assign out_valid = vld_s[NST-1];
	assign num1      = num1_s8;
	assign den1      = den1_s8;
	assign num2      = num2_s8;
	assign den2      = den2_s8;
	assign geom      = geom_s[NST];

endmodule

// ===== rtl/lpca_div.sv =====
module lpca_div #(
	parameter int N_W   = 88,
	parameter int D_W   = 72,
	parameter int TAG_W = 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            in_valid,
	input  logic signed [N_W-1:0]           num,
	input  logic signed [D_W-1:0]           den,
	input  logic [TAG_W-1:0]                tag_in,
	output logic                            out_valid,
	output logic signed [lpca_pkg::RW-1:0]  quo,
	output logic [TAG_W-1:0]                tag_out
);
	import lpca_pkg::*;

	localparam int R_W = (N_W > D_W + RW) ? N_W : D_W + RW;
	localparam int NST = RW + 3;
	localparam logic [RW-1:0] MAXP = {1'b0, {(RW-1){1'b1}}};
	localparam logic [RW-1:0] MINN = {1'b1, {(RW-1){1'b0}}};

	logic             vld_s [NST];
	logic [TAG_W-1:0] tag_s [NST];

	logic [N_W-1:0] nmag_s0;
	logic [D_W-1:0] dmag_s0;

	logic [R_W-1:0] rem_s [1:RW];
	logic [D_W-1:0] dm_s  [1:RW];
	logic [RW-1:0]  q_s   [1:RW+1];
	logic           ovf_s [1:RW+1];
	logic           neg_s [0:RW+1];
	logic [RW-1:0]  quo_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NST; j++) begin
				vld_s[j] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int j = 1; j < NST; j++) begin
				vld_s[j] <= vld_s[j-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s[0] <= tag_in;
			for (int j = 1; j < NST; j++) begin
				tag_s[j] <= tag_s[j-1];
			end

			nmag_s0  <= num[N_W-1] ? N_W'(-num) : N_W'(num);
			dmag_s0  <= den[D_W-1] ? D_W'(-den) : D_W'(den);
			neg_s[0] <= num[N_W-1] ^ den[D_W-1];

			// quotient of 2^RW or more saturates
			rem_s[1] <= R_W'(nmag_s0);
			dm_s[1]  <= dmag_s0;
			q_s[1]   <= '0;
			ovf_s[1] <= R_W'(nmag_s0) >= (R_W'(dmag_s0) << RW);
			neg_s[1] <= neg_s[0];
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar k = 1; k <= RW; k++) begin : g_iter
		logic [R_W-1:0] trial;
		logic           fit;

		assign trial = R_W'(dm_s[k]) << (RW - k);
		assign fit   = rem_s[k] >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				q_s[k+1]   <= {q_s[k][RW-2:0], fit};
				ovf_s[k+1] <= ovf_s[k];
				neg_s[k+1] <= neg_s[k];
			end
		end

		if (k < RW) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1] <= fit ? rem_s[k] - trial : rem_s[k];
					dm_s[k+1]  <= dm_s[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (!neg_s[RW+1]) begin
				quo_s <= (ovf_s[RW+1] || q_s[RW+1][RW-1]) ? MAXP : q_s[RW+1];
			end else begin
				quo_s <= (ovf_s[RW+1] || (q_s[RW+1][RW-1] && (q_s[RW+1][RW-2:0] != '0)))
					? MINN : -q_s[RW+1];
			end
		end
	end

	assign out_valid = vld_s[NST-1];
	assign quo       = quo_s;
	assign tag_out   = tag_s[NST-1];

endmodule

// ===== rtl/lpca_back.sv =====
module lpca_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 in_valid,
	input  logic signed [lpca_pkg::RW-1:0]       r1,
	input  logic signed [lpca_pkg::RW-1:0]       r2,
	input  logic                                 vr,
	input  lpca_pkg::geom_t                      geom,
	output logic                                 out_valid,
	output logic [lpca_pkg::ROOT_IN_W-1:0]       radicand,
	output lpca_pkg::res_t                       res
);
	import lpca_pkg::*;

	localparam int NST = 7;
	localparam int PRW = RW + DW;
	localparam int SW  = PRW + 3;
	localparam int MSH = FSH + 1;       // halving of the sum of the two points
	localparam int EMW = SW - 1;
	localparam int EHL = EMW / 2 + 1;   // low slice of the error magnitude
	localparam int SQW = 2 * EMW + 2;
	localparam logic signed [SW-1:0] CMAX = SW'((1 << (CW - 1)) - 1);
	localparam logic signed [SW-1:0] CMIN = -CMAX - SW'(1);
	localparam logic [SW-1:0] RND = SW'((1 << MSH) - 1);

	logic [NST-1:0] vld_s;
	res_t           res_s [1:NST-1];

	logic [2:0][PRW-1:0] p1_s1, p2_s1;
	dvec_t               ac_s1, g_s1;

	logic [2:0][SW-1:0]  s_s2, e_s2;

	logic [2:0][SW-1:0]  t_s3;
	logic [2:0][EMW-1:0] emag_s3;

	logic [2:0][2*(EMW-EHL)-1:0] hh_s4;
	logic [2:0][EMW-1:0]         hl_s4;
	logic [2:0][2*EHL-1:0]       ll_s4;

	logic [2:0][SQW-1:0] sq_s5;
	logic [SQW-1:0]      sum_s6;

	logic [ROOT_IN_W-1:0] rad_s7;
	res_t                 res_s7;

	logic [2:0][CW-1:0]   mid_c;
	logic [SQW-2*FSH-1:0] y_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			logic signed [SW-1:0] q;
			q = $signed(t_s3[i]) >>> MSH;
			if (q > CMAX) begin
				mid_c[i] = CMAX[CW-1:0];
			end else if (q < CMIN) begin
				mid_c[i] = CMIN[CW-1:0];
			end else begin
				mid_c[i] = q[CW-1:0];
			end
		end
		y_c = sum_s6[SQW-1:2*FSH];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NST-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				p1_s1[i] <= r1 * $signed(geom.v[i]);
				p2_s1[i] <= r2 * $signed(geom.w[i]);
			end
			ac_s1 <= geom.ac;
			g_s1  <= geom.g;
			res_s[1] <= '{valid_res: vr, param_line1: r1, param_line2: r2, mid: '0};

			for (int i = 0; i < 3; i++) begin
				s_s2[i] <= (SW'($signed(ac_s1[i])) <<< FSH)
					+ SW'($signed(p1_s1[i])) + SW'($signed(p2_s1[i]));
				e_s2[i] <= (SW'($signed(g_s1[i])) <<< FSH)
					+ SW'($signed(p1_s1[i])) - SW'($signed(p2_s1[i]));
			end
			res_s[2] <= res_s[1];

			// bias negative sums so the shift truncates toward zero
			for (int i = 0; i < 3; i++) begin
				t_s3[i]    <= s_s2[i] + (s_s2[i][SW-1] ? RND : '0);
				emag_s3[i] <= e_s2[i][SW-1] ? EMW'(-e_s2[i]) : EMW'(e_s2[i]);
			end
			res_s[3] <= res_s[2];

			for (int i = 0; i < 3; i++) begin
				hh_s4[i] <= emag_s3[i][EMW-1:EHL] * emag_s3[i][EMW-1:EHL];
				hl_s4[i] <= emag_s3[i][EMW-1:EHL] * emag_s3[i][EHL-1:0];
				ll_s4[i] <= emag_s3[i][EHL-1:0] * emag_s3[i][EHL-1:0];
			end
			res_s[4] <= '{valid_res: res_s[3].valid_res, param_line1: res_s[3].param_line1,
				param_line2: res_s[3].param_line2, mid: mid_c};

			for (int i = 0; i < 3; i++) begin
				sq_s5[i] <= (SQW'(hh_s4[i]) << (2 * EHL)) + (SQW'(hl_s4[i]) << (EHL + 1))
					+ SQW'(ll_s4[i]);
			end
			res_s[5] <= res_s[4];

			sum_s6   <= sq_s5[0] + sq_s5[1] + sq_s5[2];
			res_s[6] <= res_s[5];

			// a radicand past the range reads as all ones: its root is the distance limit
			if (!res_s[6].valid_res) begin
				rad_s7 <= '0;
				res_s7 <= '0;
			end else begin
				rad_s7 <= (y_c[SQW-2*FSH-1:ROOT_IN_W] != '0) ? '1 : y_c[ROOT_IN_W-1:0];
				res_s7 <= res_s[6];
			end
		end
	end

	assign out_valid = vld_s[NST-1];
	assign radicand  = rad_s7;
	assign res       = res_s7;

endmodule

// ===== rtl/lpca_sqrt.sv =====
module lpca_sqrt #(
	parameter int TAG_W = 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  logic [lpca_pkg::ROOT_IN_W-1:0]    radicand,
	input  logic [TAG_W-1:0]                  tag_in,
	output logic                              out_valid,
	output logic [lpca_pkg::GAP_W-1:0]        root,
	output logic [TAG_W-1:0]                  tag_out
);
	import lpca_pkg::*;

	localparam int RMW = GAP_W + 3;

	logic                 vld_s  [GAP_W];
	logic [TAG_W-1:0]     tag_s  [GAP_W];
	logic [GAP_W-1:0]     root_s [GAP_W];
	logic [ROOT_IN_W-1:0] x_s    [GAP_W-1];
	logic [RMW-1:0]       rem_s  [GAP_W-1];

	// one root bit per stage, two radicand bits consumed each
	for (genvar k = 0; k < GAP_W; k++) begin : g_step
		logic                 v_in;
		logic [TAG_W-1:0]     t_in;
		logic [GAP_W-1:0]     r_in;
		logic [ROOT_IN_W-1:0] x_in;
		logic [RMW-1:0]       m_in;
		logic [RMW-1:0]       cur;
		logic [RMW-1:0]       trial;
		logic                 fit;

		if (k == 0) begin : g_first
			assign v_in = in_valid;
			assign t_in = tag_in;
			assign r_in = '0;
			assign x_in = radicand;
			assign m_in = '0;
		end else begin : g_next
			assign v_in = vld_s[k-1];
			assign t_in = tag_s[k-1];
			assign r_in = root_s[k-1];
			assign x_in = x_s[k-1];
			assign m_in = rem_s[k-1];
		end

		assign cur   = {m_in[RMW-3:0], x_in[2*(GAP_W-1-k) +: 2]};
		assign trial = RMW'({r_in, 2'b01});
		assign fit   = cur >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tag_s[k]  <= t_in;
				root_s[k] <= {r_in[GAP_W-2:0], fit};
			end
		end

		if (k < GAP_W - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					x_s[k]   <= x_in;
					rem_s[k] <= fit ? cur - trial : cur;
				end
			end
		end
	end

	assign out_valid = vld_s[GAP_W-1];
	assign root      = root_s[GAP_W-1];
	assign tag_out   = tag_s[GAP_W-1];

endmodule

// ===== rtl/line_pair_closest_approach.sv =====
// Closest approach of two 3D lines. Each slave transfer carries one pair of lines, each
// given by two Q8.8 points; each master transfer returns the Q16.16 line parameters r1
// and r2 of the closest points, the Q8.8 midpoint between them and their Q9.8 distance,
// with tuser set when the lines are not parallel (a parallel or degenerate pair returns
// all zeros with tuser clear). The datapath is fully pipelined: one pair enters every
// clock while s_tready is high, and a result passes through the dot products and the
// wide products, the two bit-per-stage dividers that run side by side, the midpoint and
// squared distance, the bit-per-stage square root and the output register, in that order.
// One transfer per clock is sustained as long as tready stays high; when it drops, the
// output register and a skid register absorb the stall and the whole pipeline holds
// until the skid register drains.
module line_pair_closest_approach (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// line1_start_x, line1_start_y, line1_start_z, line1_end_x, line1_end_y, line1_end_z,
	// line2_start_x, line2_start_y, line2_start_z, line2_end_x, line2_end_y, line2_end_z
	input  logic [lpca_pkg::IN_W-1:0]     s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// param_line1, param_line2, gap_distance, mid_x, mid_y, mid_z, zero fill
	output logic [lpca_pkg::OUT_W-1:0]    m_tdata,
	// valid_res
	output logic [0:0]                    m_tuser
);
	import lpca_pkg::*;

	localparam int GW = $bits(geom_t);
	localparam int TW = $bits(res_t);

	logic en;

	cvec_t a, b, c, d;

	logic                   f_valid;
	logic signed [N2_W-1:0] num2;
	logic signed [QW-1:0]   den2;
	logic signed [N1_W-1:0] num1;
	logic signed [D1_W-1:0] den1;
	geom_t                  f_geom;
	logic                   den_nz;

	logic                 d1_valid, d2_valid;
	logic signed [RW-1:0] r1, r2;
	logic [GW-1:0]        d_geom;
	logic                 d_vr;

	logic                 b_valid;
	logic [ROOT_IN_W-1:0] b_rad;
	res_t                 b_res;

	logic             q_valid;
	logic [GAP_W-1:0] q_gap;
	logic [TW-1:0]    q_res;
	logic             acc;

	logic             out_v_q, skid_v_q;
	res_t             out_res_q, skid_res_q;
	logic [GAP_W-1:0] out_gap_q, skid_gap_q;

	// unpack the input transfer
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			a[i] = s_tdata[CW*i +: CW];
			b[i] = s_tdata[CW*(3+i) +: CW];
			c[i] = s_tdata[CW*(6+i) +: CW];
			d[i] = s_tdata[CW*(9+i) +: CW];
		end
	end

	// advance the whole pipeline unless the skid register holds a result
	assign en       = !skid_v_q;
	assign s_tready = en;

	lpca_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.a         (a),
		.b         (b),
		.c         (c),
		.d         (d),
		.out_valid (f_valid),
		.num2      (num2),
		.den2      (den2),
		.num1      (num1),
		.den1      (den1),
		.geom      (f_geom)
	);

	// a zero denominator marks parallel or degenerate lines
	assign den_nz = (den2 != '0);

	lpca_div #(
		.N_W   (N1_W),
		.D_W   (D1_W),
		.TAG_W (GW)
	) u_div_r1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (f_valid),
		.num       (num1),
		.den       (den1),
		.tag_in    (f_geom),
		.out_valid (d1_valid),
		.quo       (r1),
		.tag_out   (d_geom)
	);

	lpca_div #(
		.N_W   (N2_W),
		.D_W   (QW),
		.TAG_W (1)
	) u_div_r2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (f_valid),
		.num       (num2),
		.den       (den2),
		.tag_in    (den_nz),
		.out_valid (d2_valid),
		.quo       (r2),
		.tag_out   (d_vr)
	);

	lpca_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (d1_valid && d2_valid),
		.r1        (r1),
		.r2        (r2),
		.vr        (d_vr),
		.geom      (d_geom),
		.out_valid (b_valid),
		.radicand  (b_rad),
		.res       (b_res)
	);

	lpca_sqrt #(
		.TAG_W (TW)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (b_valid),
		.radicand  (b_rad),
		.tag_in    (b_res),
		.out_valid (q_valid),
		.root      (q_gap),
		.tag_out   (q_res)
	);

	// a result leaves the pipeline on every enabled clock with a valid last stage
	assign acc = en && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || m_tready) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= acc;
			end
		end else if (acc) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || m_tready) begin
			if (skid_v_q) begin
				out_res_q <= skid_res_q;
				out_gap_q <= skid_gap_q;
			end else begin
				out_res_q <= q_res;
				out_gap_q <= q_gap;
			end
		end else if (acc) begin
			skid_res_q <= q_res;
			skid_gap_q <= q_gap;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = out_res_q.valid_res;
	assign m_tdata  = {
		(OUT_W - 2*RW - GAP_W - 3*CW)'(0),
		out_res_q.mid[2],
		out_res_q.mid[1],
		out_res_q.mid[0],
		out_gap_q,
		out_res_q.param_line2,
		out_res_q.param_line1
	};

endmodule

// ===== tb/line_pair_closest_approach_test.sv =====
module line_pair_closest_approach_test;
	import lpca_pkg::*;

	localparam int HALF_PERIOD = 2;
	localparam int LATENCY     = 68;
	localparam int STALL_LIMIT = 4000;
	localparam int GAP_SAT     = 131071;

	typedef struct packed {
		logic              valid_res;
		logic [31:0]       param_line1;
		logic [31:0]       param_line2;
		logic [16:0]       gap_distance;
		logic [2:0][15:0]  mid;
	} approach_t;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	// line1_start_x/y/z, line1_end_x/y/z, line2_start_x/y/z, line2_end_x/y/z
	logic [IN_W-1:0]   s_tdata;
	logic              m_tvalid;
	logic              m_tready;
	// param_line1, param_line2, gap_distance, mid_x, mid_y, mid_z, zero fill
	logic [OUT_W-1:0]  m_tdata;
	// valid_res
	logic [0:0]        m_tuser;

	approach_t         approach_q[$];
	int                errors;
	int                idle_cycles;
	bit                no_gaps;
	bit                no_stalls;

	line_pair_closest_approach u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #HALF_PERIOD clk = ~clk;

	// Saturate a wide quotient to the signed 32-bit range of a Q16.16 parameter.
	function automatic longint sat_param(input logic signed [255:0] q);
		logic signed [255:0] lo, hi;
		lo = -(longint'(1) <<< 31);
		hi = (longint'(1) <<< 31) - 1;
		if (q < lo)
			return -(longint'(1) <<< 31);
		if (q > hi)
			return (longint'(1) <<< 31) - 1;
		return longint'(q);
	endfunction

	// Work out the closest approach of the line pair packed in one slave transfer.
	function automatic approach_t closest_approach(input logic [IN_W-1:0] d);
		longint a[3], b[3], c[3], e[3], v[3], w[3], g[3];
		longint v2, w2, vw, gv, gw, r1, r2, s, m, dv;
		logic signed [255:0] bv2, bw2, bvw, bgv, bgw, den, num, n1, be, sq, root, cand;
		approach_t r;
		r = '0;
		for (int i = 0; i < 3; i++) begin
			a[i] = longint'(signed'(d[16*i +: 16]));
			b[i] = longint'(signed'(d[16*(3+i) +: 16]));
			c[i] = longint'(signed'(d[16*(6+i) +: 16]));
			e[i] = longint'(signed'(d[16*(9+i) +: 16]));
			v[i] = b[i] - a[i];
			w[i] = e[i] - c[i];
			g[i] = a[i] - c[i];
		end
		v2 = 0; w2 = 0; vw = 0; gv = 0; gw = 0;
		for (int i = 0; i < 3; i++) begin
			v2 += v[i] * v[i];
			w2 += w[i] * w[i];
			vw += v[i] * w[i];
			gv += g[i] * v[i];
			gw += g[i] * w[i];
		end
		bv2 = v2; bw2 = w2; bvw = vw; bgv = gv; bgw = gw;
		den = bv2 * bw2 - bvw * bvw;
		// parallel pair or a line collapsed to a point: all zeros, flag clear
		if (den == 0 || v2 == 0)
			return r;
		num = bv2 * bgw - bgv * bvw;
		r2 = sat_param((num <<< 16) / den);
		n1 = num * bvw - bgv * den;
		r1 = sat_param((n1 <<< 16) / (den * bv2));
		sq = 0;
		for (int i = 0; i < 3; i++) begin
			// halve the sum of both closest points, truncating toward zero
			s = (a[i] + c[i]) * 65536 + r1 * v[i] + r2 * w[i];
			m = s / 131072;
			if (m < -32768)
				m = -32768;
			if (m > 32767)
				m = 32767;
			r.mid[i] = m[15:0];
			dv = g[i] * 65536 + r1 * v[i] - r2 * w[i];
			be = dv;
			sq += be * be;
		end
		root = 0;
		for (int k = 52; k >= 0; k--) begin
			cand = root | (256'(1) << k);
			if (cand * cand <= sq)
				root = cand;
		end
		root = root >>> 16;
		if (root > GAP_SAT)
			root = GAP_SAT;
		r.valid_res    = 1'b1;
		r.param_line1  = r1[31:0];
		r.param_line2  = r2[31:0];
		r.gap_distance = root[16:0];
		return r;
	endfunction

	function automatic int pick_gap();
		int p;
		p = $urandom_range(99);
		if (p < 60)
			return 0;
		if (p < 92)
			return $urandom_range(3, 1);
		return $urandom_range(40, 5);
	endfunction

	// Offer one pair, hold it until the transfer, then optionally drop valid for a gap.
	task automatic send_pair(input logic [IN_W-1:0] d);
		int gap;
		s_tdata  <= d;
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		approach_q.push_back(closest_approach(d));
		gap = no_gaps ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [IN_W-1:0] pack_pair(input logic [15:0] p[12]);
		logic [IN_W-1:0] d;
		for (int i = 0; i < 12; i++)
			d[16*i +: 16] = p[i];
		return d;
	endfunction

	function automatic logic [15:0] rand_coord(input int span);
		if (span == 0)
			return 16'($urandom);
		return 16'($urandom_range(2 * span) - span);
	endfunction

	task automatic test_directed();
		logic [15:0] p[12];
		// everything zero: both lines degenerate
		p = '{default: 16'h0000};
		send_pair(pack_pair(p));
		// all coordinates at the positive and negative extremes
		p = '{default: 16'h7fff};
		send_pair(pack_pair(p));
		p = '{default: 16'h8000};
		send_pair(pack_pair(p));
		// widest spans: a at min, b at max, crossing line the other way round
		p = '{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff,
			16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff};
		send_pair(pack_pair(p));
		p = '{16'h8000, 16'h0000, 16'h7fff, 16'h7fff, 16'h0000, 16'h8000,
			16'h0000, 16'h8000, 16'h0000, 16'h0000, 16'h7fff, 16'h0000};
		send_pair(pack_pair(p));
		// x axis and y axis crossing at the origin
		p = '{16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0000,
			16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0000};
		send_pair(pack_pair(p));
		// skew lines one unit apart in z
		p = '{16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0000,
			16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0100, 16'h0100};
		send_pair(pack_pair(p));
		// parallel lines, offset in y
		p = '{16'h0000, 16'h0000, 16'h0000, 16'h0200, 16'h0100, 16'h0000,
			16'h0000, 16'h0300, 16'h0000, 16'h0400, 16'h0500, 16'h0000};
		send_pair(pack_pair(p));
		// identical lines
		p = '{16'h0100, 16'h0200, 16'h0300, 16'hff00, 16'h0000, 16'h0400,
			16'h0100, 16'h0200, 16'h0300, 16'hff00, 16'h0000, 16'h0400};
		send_pair(pack_pair(p));
		// line 1 collapsed to a point, line 2 collapsed to a point
		p = '{16'h0300, 16'h0300, 16'h0300, 16'h0300, 16'h0300, 16'h0300,
			16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0000};
		send_pair(pack_pair(p));
		p = '{16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0000,
			16'h0300, 16'hfd00, 16'h0300, 16'h0300, 16'hfd00, 16'h0300};
		send_pair(pack_pair(p));
		// a short first line far from the second, with coordinates at the range limits
		p = '{16'h8000, 16'h8000, 16'h8000, 16'h8001, 16'h8000, 16'h8000,
			16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000};
		send_pair(pack_pair(p));
		p = '{16'h7fff, 16'h0000, 16'h0000, 16'h7ffe, 16'h0001, 16'h0000,
			16'h8000, 16'h0000, 16'h0000, 16'h8001, 16'h0001, 16'h0001};
		send_pair(pack_pair(p));
		// smallest steps
		p = '{16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000,
			16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0001, 16'h0001};
		send_pair(pack_pair(p));
	endtask

	// Build a parallel or degenerate pair with random content.
	task automatic test_parallel(input int count);
		logic [15:0] p[12];
		int k, dx, dy, dz;
		for (int n = 0; n < count; n++) begin
			k  = $urandom_range(4) - 2;
			dx = $urandom_range(2000) - 1000;
			dy = $urandom_range(2000) - 1000;
			dz = $urandom_range(2000) - 1000;
			for (int i = 0; i < 3; i++) begin
				p[i]     = rand_coord(8000);
				p[6 + i] = rand_coord(8000);
			end
			p[3]  = 16'(int'(signed'(p[0])) + dx);
			p[4]  = 16'(int'(signed'(p[1])) + dy);
			p[5]  = 16'(int'(signed'(p[2])) + dz);
			p[9]  = 16'(int'(signed'(p[6])) + k * dx);
			p[10] = 16'(int'(signed'(p[7])) + k * dy);
			p[11] = 16'(int'(signed'(p[8])) + k * dz);
			send_pair(pack_pair(p));
		end
	endtask

	// Mostly well-formed skew pairs at a random scale; full-range noise in between.
	task automatic test_random(input int count);
		logic [15:0] p[12];
		int span;
		for (int n = 0; n < count; n++) begin
			if (n % 100 == 0) begin
				no_gaps   = ($urandom_range(3) == 0);
				no_stalls = ($urandom_range(3) == 0);
			end
			case ($urandom_range(3))
				0: span = 0;
				1: span = 32767;
				2: span = 2048;
				default: span = 64;
			endcase
			for (int i = 0; i < 12; i++)
				p[i] = rand_coord(span);
			send_pair(pack_pair(p));
		end
		no_gaps   = 1'b0;
		no_stalls = 1'b0;
	endtask

	task automatic check_field(input string name, input longint expv, input longint act);
		if (expv != act) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, expv, act);
			errors++;
		end
	endtask

	// Compare each result transfer with the oldest prediction; randomize back-pressure.
	always @(posedge clk) begin
		approach_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (approach_q.size() == 0) begin
				$display("%0t: unexpected result, got %h tuser %b", $time, m_tdata, m_tuser);
				errors++;
			end else begin
				want = approach_q.pop_front();
				check_field("valid_res", want.valid_res, m_tuser[0]);
				check_field("param_line1", want.param_line1, m_tdata[31:0]);
				check_field("param_line2", want.param_line2, m_tdata[63:32]);
				check_field("gap_distance", want.gap_distance, m_tdata[80:64]);
				check_field("mid_x", want.mid[0], m_tdata[96:81]);
				check_field("mid_y", want.mid[1], m_tdata[112:97]);
				check_field("mid_z", want.mid[2], m_tdata[128:113]);
				check_field("zero fill", 0, m_tdata[135:129]);
			end
		end
		if (no_stalls)
			m_tready <= 1'b1;
		else
			m_tready <= ($urandom_range(99) < 70);
	end

	// Watchdog: count cycles with no transfer on either side.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("line_pair_closest_approach test failed");
			$finish;
		end
	end

	initial begin
		clk         = 1'b0;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		m_tready    = 1'b0;
		errors      = 0;
		idle_cycles = 0;
		no_gaps     = 1'b0;
		no_stalls   = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_parallel(40);
		test_random(700);
		s_tvalid <= 1'b0;
		while (approach_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0)
			$display("line_pair_closest_approach test passed");
		else
			$display("line_pair_closest_approach test failed");
		$finish;
	end

endmodule
